[rtl/ranked_list_insert_remove_top_assert.svh]
// Assertion macros used by the checker file of the ranked list.
`ifndef RANKED_LIST_INSERT_REMOVE_TOP_ASSERT_SVH
`define RANKED_LIST_INSERT_REMOVE_TOP_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define RLI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define RLI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/rli_pkg.sv]
// Package with sizes, codes, command type and data conversions of the ranked list.
package rli_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int POS_W      = 5;
    localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [2:0] {
        ACT_READ   = 3'd0,
        ACT_WRITE  = 3'd1,
        ACT_INSERT = 3'd2,
        ACT_REMOVE = 3'd3,
        ACT_PUSH   = 3'd4,
        ACT_POP    = 3'd5,
        ACT_TOP    = 3'd6
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANK  = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef struct packed {
        logic                  wr;
        logic                  ins;
        logic                  rem;
        logic [IDX_W-1:0]      pos;
        logic [DATA_WIDTH-1:0] val;
    } t_cell_cmd;

    function automatic logic [DATA_WIDTH-1:0] to_store(input logic [31:0] v);
        logic signed [63:0] w;
        w = 64'(signed'(v));
        return w[DATA_WIDTH-1:0];
    endfunction

    function automatic logic [31:0] to_out(input logic [DATA_WIDTH-1:0] v);
        logic signed [63:0] w;
        w = 64'(signed'(v));
        return w[31:0];
    endfunction

endpackage

[rtl/rli_if.sv]
// Request and response channel interfaces of the ranked list.
interface rli_req_if import rli_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [2:0]              action;
    logic [POS_W-1:0]        position;
    logic signed [31:0]      item_value;

    modport source (output valid, action, position, item_value, input ready);
    modport sink (input valid, action, position, item_value, output ready);
endinterface

interface rli_rsp_if import rli_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [31:0]      read_data;
    logic [4:0]              entry_count;
    logic                    is_empty;
    logic [1:0]              status;

    modport source (output valid, read_data, entry_count, is_empty, status, input ready);
    modport sink (input valid, read_data, entry_count, is_empty, status, output ready);
endinterface

[rtl/rli_cell.sv]
// One storage cell of the list chain, shifting with its neighbors on insert and remove.
module rli_cell import rli_pkg::*; (
    input  logic                  i_clk,
    input  t_cell_cmd             i_cmd,
    input  logic [IDX_W-1:0]      i_index,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    output logic [DATA_WIDTH-1:0] o_value
);

    logic [DATA_WIDTH-1:0] r_value;
    logic [DATA_WIDTH-1:0] n_value;
    logic                  here;
    logic                  above;

    always_comb begin
        here    = (i_cmd.pos == i_index);
        above   = (i_index > i_cmd.pos);
        n_value = r_value;
        if (i_cmd.wr && here) begin
            n_value = i_cmd.val;
        end else if (i_cmd.ins) begin
            if (here) begin
                n_value = i_cmd.val;
            end else if (above) begin
                n_value = i_left;
            end
        end else if (i_cmd.rem && (here || above)) begin
            n_value = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

[rtl/ranked_list_insert_remove_top.sv]
// Top level of the ranked list: request decode, count, cell chain and response register.
//
// Requests arrive on i_req (action, position, item_value) and each produces exactly
// one response on o_rsp (read_data, entry_count, is_empty, status), in order.
// A request is decoded and applied to the whole chain of cells in the cycle of its
// transfer: every cell loads its own value, its neighbor's or the new value at once,
// so insert and remove shift all entries in parallel.
// The response is registered and appears in the cycle after the request transfer.
// Throughput is one request per cycle while the receiver does not stall; the count
// register and the single response register set this figure.
// While the receiver stalls, the response register holds its contents and i_req.ready
// stays low until that response is taken; in the cycle it is taken a new request can
// transfer.
// Reset empties the list, drops any pending response and holds i_req.ready low;
// cell contents are not cleared and are never read before they are written.
module ranked_list_insert_remove_top import rli_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    rli_req_if.sink  i_req,
    rli_rsp_if.source o_rsp
);

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_out_valid;
    logic [31:0]           r_read_data;
    logic [CNT_W-1:0]      r_entry_count;
    t_status               r_status;

    logic                  accept;
    logic [CMP_W-1:0]      pos_ext;
    logic [CMP_W-1:0]      cnt_ext;
    logic [CNT_W-1:0]      cnt_m1;
    logic                  in_range;
    logic                  is_full;
    logic                  no_entries;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_idx;
    logic [31:0]           data;
    t_status               st;
    t_cell_cmd             cmd;
    logic [DATA_WIDTH-1:0] cell_val [DEPTH];

    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = i_rst_n && (!r_out_valid || o_rsp.ready);

    always_comb begin
        pos_ext    = CMP_W'(i_req.position);
        cnt_ext    = CMP_W'(r_count);
        cnt_m1     = r_count - CNT_W'(1);
        in_range   = (pos_ext < cnt_ext);
        is_full    = (r_count == CNT_W'(DEPTH));
        no_entries = (r_count == '0);
        rd_en      = 1'b0;
        rd_idx     = pos_ext[IDX_W-1:0];
        st         = ST_OK;
        n_count    = r_count;
        cmd.wr     = 1'b0;
        cmd.ins    = 1'b0;
        cmd.rem    = 1'b0;
        cmd.pos    = pos_ext[IDX_W-1:0];
        cmd.val    = to_store(i_req.item_value);
        case (t_action'(i_req.action))
            ACT_READ: begin
                if (in_range) begin
                    rd_en = 1'b1;
                end else begin
                    st = ST_RANK;
                end
            end
            ACT_WRITE: begin
                if (in_range) begin
                    cmd.wr = 1'b1;
                end else begin
                    st = ST_RANK;
                end
            end
            ACT_INSERT: begin
                if (pos_ext > cnt_ext) begin
                    st = ST_RANK;
                end else if (is_full) begin
                    st = ST_FULL;
                end else begin
                    cmd.ins = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            ACT_REMOVE: begin
                if (in_range) begin
                    rd_en   = 1'b1;
                    cmd.rem = 1'b1;
                    n_count = cnt_m1;
                end else begin
                    st = ST_RANK;
                end
            end
            ACT_PUSH: begin
                if (is_full) begin
                    st = ST_FULL;
                end else begin
                    cmd.ins = 1'b1;
                    cmd.pos = r_count[IDX_W-1:0];
                    n_count = r_count + CNT_W'(1);
                end
            end
            ACT_POP: begin
                if (no_entries) begin
                    st = ST_EMPTY;
                end else begin
                    rd_en   = 1'b1;
                    rd_idx  = cnt_m1[IDX_W-1:0];
                    cmd.rem = 1'b1;
                    cmd.pos = cnt_m1[IDX_W-1:0];
                    n_count = cnt_m1;
                end
            end
            ACT_TOP: begin
                if (no_entries) begin
                    st = ST_EMPTY;
                end else begin
                    rd_en  = 1'b1;
                    rd_idx = cnt_m1[IDX_W-1:0];
                end
            end
            default: begin
            end
        endcase
        cmd.wr  = cmd.wr && accept;
        cmd.ins = cmd.ins && accept;
        cmd.rem = cmd.rem && accept;
        data    = rd_en ? to_out(cell_val[rd_idx]) : 32'd0;
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        rli_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cmd),
            .i_index (IDX_W'(g)),
            .i_left  ((g == 0) ? cell_val[g] : cell_val[(g == 0) ? 0 : g - 1]),
            .i_right ((g == DEPTH - 1) ? cell_val[g] : cell_val[(g == DEPTH - 1) ? g : g + 1]),
            .o_value (cell_val[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_read_data   <= data;
            r_entry_count <= n_count;
            r_status      <= st;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.read_data   = r_read_data;
    assign o_rsp.entry_count = 5'(r_entry_count);
    assign o_rsp.is_empty    = (r_entry_count == '0);
    assign o_rsp.status      = r_status;

endmodule

[rtl/rli_checker.sv]
// Port-level checker of the ranked list and its binding to the top level.
`include "ranked_list_insert_remove_top_assert.svh"

module rli_checker import rli_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_read_data,
    input logic [4:0]  i_entry_count,
    input logic        i_is_empty,
    input logic [1:0]  i_status
);

    `RLI_ASSERT_NEXT(a_rsp_follows, i_clk, i_rst_n, i_in_valid && i_in_ready, i_out_valid, "response missing after request transfer")
    `RLI_ASSERT_NEXT(a_rsp_held, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_read_data) && $stable(i_status), "stalled response changed")
    `RLI_ASSERT(a_empty_flag, i_clk, i_rst_n, !i_out_valid || (i_is_empty == (i_entry_count == 5'd0)), "empty flag disagrees with count")
    `RLI_ASSERT(a_err_zero, i_clk, i_rst_n, !i_out_valid || i_status == ST_OK || i_read_data == 32'd0, "error response carries data")

endmodule

bind ranked_list_insert_remove_top rli_checker u_rli_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_req.valid),
    .i_in_ready    (i_req.ready),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_read_data   (o_rsp.read_data),
    .i_entry_count (o_rsp.entry_count),
    .i_is_empty    (o_rsp.is_empty),
    .i_status      (o_rsp.status)
);

[bench/tb_ranked_list_insert_remove_top.sv]
// Testbench of the ranked list: random and directed requests checked against a predicted list.
`timescale 1ns / 100ps

module tb_ranked_list_insert_remove_top import rli_pkg::*;;

    localparam logic [2:0] ACT_UNUSED  = 3'd7;
    localparam int         HOLD_CYCLES = 80;
    localparam int         QUIET_LIMIT = 2000;
    localparam int         MAX_REPORTS = 10;

    typedef struct packed {
        logic [2:0]         action;
        logic [POS_W-1:0]   position;
        logic signed [31:0] item_value;
    } list_req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [4:0]  entry_count;
        logic        is_empty;
        t_status     status;
    } list_rsp_t;

    logic clk;
    logic rst_n;

    rli_req_if req_if ();
    rli_rsp_if rsp_if ();

    list_req_t pending_requests[$];
    list_rsp_t expected_responses[$];

    logic [DATA_WIDTH-1:0] list_vals [DEPTH];
    int held_count = 0;
    int plan_count = 0;
    bit plan_grow  = 1'b1;

    int error_count  = 0;
    int quiet_cycles = 0;
    int hold_left    = 0;
    int tx_idle_pct;
    int rx_idle_pct;
    bit tx_pause;
    bit hold_trigger;

    ranked_list_insert_remove_top DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] as_output(input logic [DATA_WIDTH-1:0] v);
        logic signed [DATA_WIDTH-1:0] narrow;
        logic signed [63:0]           wide;
        narrow = v;
        wide   = 64'(narrow);
        return wide[31:0];
    endfunction

    function automatic list_rsp_t predict_response(input list_req_t req);
        list_rsp_t             rsp;
        int                    rank;
        logic signed [63:0]    wide;
        logic [DATA_WIDTH-1:0] stored;
        rank   = int'(req.position);
        wide   = 64'(req.item_value);
        stored = wide[DATA_WIDTH-1:0];
        rsp.read_data = '0;
        rsp.status    = ST_OK;
        case (req.action)
            ACT_READ: begin
                if (rank < held_count) rsp.read_data = as_output(list_vals[rank]);
                else rsp.status = ST_RANK;
            end
            ACT_WRITE: begin
                if (rank < held_count) list_vals[rank] = stored;
                else rsp.status = ST_RANK;
            end
            ACT_INSERT, ACT_PUSH: begin
                if (req.action == ACT_PUSH) rank = held_count;
                if (rank > held_count) begin
                    rsp.status = ST_RANK;
                end else if (held_count >= DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    for (int i = held_count; i > rank; i--) list_vals[i] = list_vals[i-1];
                    list_vals[rank] = stored;
                    held_count++;
                end
            end
            ACT_REMOVE, ACT_POP: begin
                if (req.action == ACT_POP) rank = held_count - 1;
                if (req.action == ACT_POP && held_count == 0) begin
                    rsp.status = ST_EMPTY;
                end else if (rank >= held_count) begin
                    rsp.status = ST_RANK;
                end else begin
                    rsp.read_data = as_output(list_vals[rank]);
                    for (int i = rank; i + 1 < held_count; i++) list_vals[i] = list_vals[i+1];
                    held_count--;
                end
            end
            ACT_TOP: begin
                if (held_count == 0) rsp.status = ST_EMPTY;
                else rsp.read_data = as_output(list_vals[held_count-1]);
            end
            default: begin
            end
        endcase
        rsp.entry_count = 5'(held_count);
        rsp.is_empty    = (held_count == 0);
        return rsp;
    endfunction

    task automatic queue_request(input logic [2:0] act, input int pos, input logic [31:0] value);
        list_req_t req;
        req.action     = act;
        req.position   = POS_W'(pos);
        req.item_value = value;
        pending_requests.push_back(req);
        case (act)
            ACT_INSERT: if (pos <= plan_count && plan_count < DEPTH) plan_count++;
            ACT_PUSH:   if (plan_count < DEPTH) plan_count++;
            ACT_REMOVE: if (pos < plan_count) plan_count--;
            ACT_POP:    if (plan_count > 0) plan_count--;
            default: begin
            end
        endcase
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // The list is driven from empty to full and back so that both limits are met often.
    task automatic queue_random(input int n);
        int          r;
        int          pos;
        logic [2:0]  act;
        for (int k = 0; k < n; k++) begin
            if (plan_grow && plan_count == DEPTH && $urandom_range(0, 3) == 0) plan_grow = 1'b0;
            if (!plan_grow && plan_count == 0 && $urandom_range(0, 3) == 0) plan_grow = 1'b1;
            if ($urandom_range(0, 99) < 8) begin
                act = 3'($urandom_range(0, 7));
                pos = $urandom_range(0, 31);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 30)      act = plan_grow ? ACT_PUSH : ACT_POP;
                else if (r < 60) act = plan_grow ? ACT_INSERT : ACT_REMOVE;
                else if (r < 70) act = ACT_READ;
                else if (r < 80) act = ACT_WRITE;
                else if (r < 88) act = ACT_TOP;
                else if (r < 94) act = plan_grow ? ACT_REMOVE : ACT_PUSH;
                else             act = plan_grow ? ACT_POP : ACT_INSERT;
                case (act)
                    ACT_INSERT: pos = $urandom_range(0, plan_count);
                    ACT_READ, ACT_WRITE, ACT_REMOVE:
                        pos = (plan_count == 0) ? 0 : $urandom_range(0, plan_count - 1);
                    default: pos = $urandom_range(0, 31);
                endcase
            end
            queue_request(act, pos, pick_value());
        end
    endtask

    task automatic drain();
        while (pending_requests.size() != 0 || req_if.valid || expected_responses.size() != 0)
            @(negedge clk);
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (error_count < MAX_REPORTS)
            $display("%0t: mismatch in %s: expected %0h, got %0h", $time, what, want, got);
        error_count++;
    endtask

    always @(posedge clk) begin : drive_proc
        list_req_t next_req;
        if (!rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                next_req.action     = req_if.action;
                next_req.position   = req_if.position;
                next_req.item_value = req_if.item_value;
                expected_responses.push_back(predict_response(next_req));
            end
            if (!req_if.valid || req_if.ready) begin
                if (pending_requests.size() != 0 && !tx_pause &&
                    $urandom_range(0, 99) >= tx_idle_pct) begin
                    next_req = pending_requests.pop_front();
                    req_if.valid      <= 1'b1;
                    req_if.action     <= next_req.action;
                    req_if.position   <= next_req.position;
                    req_if.item_value <= next_req.item_value;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin : check_proc
        list_rsp_t want;
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_responses.size() == 0) begin
                    note_mismatch("unexpected response, read_data", '0, rsp_if.read_data);
                end else begin
                    want = expected_responses.pop_front();
                    if (rsp_if.read_data !== want.read_data)
                        note_mismatch("read_data", want.read_data, rsp_if.read_data);
                    if (rsp_if.entry_count !== want.entry_count)
                        note_mismatch("entry_count", 32'(want.entry_count),
                                      32'(rsp_if.entry_count));
                    if (rsp_if.is_empty !== want.is_empty)
                        note_mismatch("is_empty", 32'(want.is_empty), 32'(rsp_if.is_empty));
                    if (rsp_if.status !== want.status)
                        note_mismatch("status", 32'(want.status), 32'(rsp_if.status));
                end
            end
            if (hold_trigger) begin
                hold_left = HOLD_CYCLES;
                rsp_if.ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin : stimulus_proc
        rst_n             = 1'b0;
        req_if.valid      = 1'b0;
        req_if.action     = ACT_READ;
        req_if.position   = '0;
        req_if.item_value = '0;
        rsp_if.ready      = 1'b0;
        tx_idle_pct       = 35;
        rx_idle_pct       = 66;
        tx_pause          = 1'b0;
        hold_trigger      = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        queue_request(ACT_TOP, 0, 32'h0);
        queue_request(ACT_POP, 0, 32'h0);
        queue_request(ACT_READ, 0, 32'h0);
        queue_request(ACT_WRITE, 0, 32'h1234_5678);
        queue_request(ACT_REMOVE, 0, 32'h0);
        queue_request(ACT_INSERT, 1, 32'h1);
        queue_request(ACT_INSERT, 0, 32'h7FFF_FFFF);
        queue_request(ACT_PUSH, 0, 32'h8000_0000);
        queue_request(ACT_INSERT, 1, 32'h0);
        queue_request(ACT_PUSH, 31, 32'hFFFF_FFFF);
        queue_request(ACT_READ, 0, 32'h0);
        queue_request(ACT_READ, 31, 32'h0);
        queue_request(ACT_WRITE, 2, 32'hAAAA_AAAA);
        queue_request(ACT_READ, 2, 32'h0);
        queue_request(ACT_INSERT, 4, 32'h5555_5555);
        queue_request(ACT_INSERT, 6, 32'h2);
        queue_request(ACT_REMOVE, 0, 32'h0);
        queue_request(ACT_REMOVE, 4, 32'h0);
        queue_request(ACT_TOP, 16, 32'h0);
        queue_request(ACT_POP, 0, 32'h0);
        queue_request(ACT_UNUSED, 31, 32'hFFFF_FFFF);
        queue_request(ACT_WRITE, 16, 32'h3);
        queue_random(290);
        drain();

        tx_idle_pct = 66;
        rx_idle_pct = 35;
        queue_random(300);
        drain();

        // The receiver holds off while requests keep coming, so the block stalls its input.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        queue_random(160);
        hold_trigger = 1'b1;
        @(negedge clk);
        hold_trigger = 1'b0;
        while (pending_requests.size() > 80) @(negedge clk);
        tx_pause = 1'b1;
        while (req_if.valid || expected_responses.size() != 0) @(negedge clk);
        repeat (15) @(negedge clk);
        tx_pause = 1'b0;
        queue_random(170);
        drain();

        repeat (8) @(posedge clk);
        if (error_count == 0 && expected_responses.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
